@@ hdl/arm_pkg.sv @@
// ----------------------------------------------------------------------------
// Road matcher package
// Shared widths, operation codes and payload types of the road matcher.
// ----------------------------------------------------------------------------
package arm_pkg;

	localparam int NumLayersDef   = 6;
	localparam int NumRoadsDef    = 256;
	localparam int PatternBitsDef = 18;

	localparam int OpW     = 2;
	localparam int LayerW  = 3;
	localparam int StubW   = 18;
	localparam int RoadIdW = 8;
	localparam int RoadNoW = 8;

	typedef enum logic [OpW-1:0] {
		OP_LOAD  = 2'd0,
		OP_STUB  = 2'd1,
		OP_POP   = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		logic [OpW-1:0]     operation;
		logic [LayerW-1:0]  layer;
		logic [StubW-1:0]   stub_pattern;
		logic [RoadIdW-1:0] road_index;
	} in_word_t;

	typedef struct packed {
		logic [RoadNoW-1:0] road_number;
		logic               found;
	} out_word_t;

	// Command broadcast along the chain of cells.
	typedef struct packed {
		logic               load;
		logic               stub;
		logic               clear;
		logic [LayerW-1:0]  layer;
		logic [StubW-1:0]   pattern;
		logic [RoadIdW-1:0] road;
	} cell_cmd_t;

endpackage

@@ hdl/arm_stream_if.sv @@
// ----------------------------------------------------------------------------
// Road matcher stream interface
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface arm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/arm_cell.sv @@
// ----------------------------------------------------------------------------
// Road matcher cell
// One road: its stored patterns, hit mask and sent flag, and one link of the
// priority chain that finds the lowest ready road.
// ----------------------------------------------------------------------------
module arm_cell #(
	parameter int NumLayers   = arm_pkg::NumLayersDef,
	parameter int PatternBits = arm_pkg::PatternBitsDef,
	parameter int RoadW       = 8,
	parameter logic [RoadW-1:0] RoadId = '0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  arm_pkg::cell_cmd_t cmd,
	input  logic              pop,
	input  logic              taken_in,
	output logic              taken_out
);
	logic [NumLayers-1:0][PatternBits-1:0] pat_q;
	logic [NumLayers-1:0] hits_q;
	logic                 sent_q;
	logic                 ready_road;
	logic                 road_hit;
	logic [PatternBits-1:0] cmd_pat;

	assign road_hit   = (32'(cmd.road) == 32'(RoadId));
	assign cmd_pat    = PatternBits'(cmd.pattern);
	assign ready_road = (&hits_q) && !sent_q;
	assign taken_out  = taken_in || ready_road;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NumLayers; l++) begin
				pat_q[l] <= PatternBits'(RoadId);
			end
			hits_q <= '0;
			sent_q <= 1'b0;
		end else begin
			for (int l = 0; l < NumLayers; l++) begin
				if (cmd.load && road_hit && (32'(cmd.layer) == l)) begin
					pat_q[l] <= cmd_pat;
				end
				if (cmd.stub && (32'(cmd.layer) == l) &&
					(pat_q[l] == cmd_pat)) begin
					hits_q[l] <= 1'b1;
				end
			end
			if (cmd.clear) begin
				hits_q <= '0;
				sent_q <= 1'b0;
			end else if (pop && ready_road && !taken_in) begin
				sent_q <= 1'b1;
			end
		end
	end
endmodule

@@ hdl/associative_road_matcher_core.sv @@
// ----------------------------------------------------------------------------
// Associative road matcher core
// Content-addressed road store with per-layer hit tracking and road readout.
// ----------------------------------------------------------------------------
// Every word acts on all roads at once: each road is a cell holding its
// patterns and hit mask, so a stub compares against every road in
// parallel. A pop walks the priority chain through all cells in the same
// cycle and its result is registered, appearing in the cycle after
// acceptance; the input stalls only while that result waits to be taken.
module associative_road_matcher_core #(
	parameter int NumLayers   = arm_pkg::NumLayersDef,
	parameter int NumRoads    = arm_pkg::NumRoadsDef,
	parameter int PatternBits = arm_pkg::PatternBitsDef
) (
	input logic clk,
	input logic arst_n,
	arm_stream_if.sink   in_ch,
	arm_stream_if.source out_ch
);
	localparam int RoadW = (NumRoads > 1) ? $clog2(NumRoads) : 1;

	arm_pkg::in_word_t  w;
	arm_pkg::cell_cmd_t cmd;
	arm_pkg::out_word_t res_q;
	logic               out_valid_q;
	logic               acc;
	logic               pop;
	logic [NumRoads:0]  chain;
	logic [RoadW-1:0]   first;
	logic               any;
	logic               layer_ok;

	assign w        = in_ch.data;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign acc      = in_ch.valid && in_ch.ready;
	assign layer_ok = 32'(w.layer) < NumLayers;
	assign pop      = acc && (w.operation == arm_pkg::OP_POP);

	always_comb begin
		cmd         = '0;
		cmd.layer   = w.layer;
		cmd.pattern = w.stub_pattern;
		cmd.road    = w.road_index;
		cmd.load    = acc && (w.operation == arm_pkg::OP_LOAD) && layer_ok &&
			(32'(w.road_index) < NumRoads);
		cmd.stub    = acc && (w.operation == arm_pkg::OP_STUB) && layer_ok;
		cmd.clear   = acc && (w.operation == arm_pkg::OP_CLEAR);
	end

	assign chain[0] = 1'b0;
	genvar g;
	generate
		for (g = 0; g < NumRoads; g++) begin : g_cell
			arm_cell #(
				.NumLayers(NumLayers), .PatternBits(PatternBits),
				.RoadW(RoadW), .RoadId(RoadW'(g))
			) u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd), .pop(pop),
				.taken_in(chain[g]), .taken_out(chain[g+1])
			);
		end
	endgenerate

	always_comb begin
		first = '0;
		for (int r = NumRoads - 1; r >= 0; r--) begin
			if (chain[r+1] && !chain[r]) begin
				first = RoadW'(r);
			end
		end
	end
	assign any = chain[NumRoads];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.found       <= any;
			res_q.road_number <= any ?
				arm_pkg::RoadNoW'({{arm_pkg::RoadNoW{1'b0}}, first}) : '0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = res_q;
endmodule
